FILE: hdl/iub_pkg.sv
// Shared types and constants of the UART / I2C bridge controller.
`default_nettype none
package iub_pkg;

   localparam int DEF_SERIAL_DEPTH = 64;
   localparam int DEF_BUS_DEPTH    = 64;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_LEVEL  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_ADDRESS = 2'd1;

   localparam logic [6:0] TRIGGER_RESET = 7'd16;

   // I2C status codes (prescaler bits masked)
   localparam logic [7:0] I2C_MT_START     = 8'h08;
   localparam logic [7:0] I2C_MT_SLA_ACK   = 8'h18;
   localparam logic [7:0] I2C_MT_DATA_ACK  = 8'h28;
   localparam logic [7:0] I2C_MT_DATA_NACK = 8'h30;
   localparam logic [7:0] I2C_ARB_LOST     = 8'h38;
   localparam logic [7:0] I2C_SR_SLA_ACK   = 8'h60;
   localparam logic [7:0] I2C_SR_DATA_ACK  = 8'h80;
   localparam logic [7:0] I2C_SR_STOP      = 8'hA0;

   typedef enum logic [1:0] {
      FUNC_UART_RX    = 2'd0,
      FUNC_BUS_STATUS = 2'd1,
      FUNC_TX_EMPTY   = 2'd2,
      FUNC_POLL       = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_SEND  = 3'd2,
      CMD_STOP  = 3'd3,
      CMD_ACK   = 3'd4,
      CMD_NACK  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_STOPPED   = 2'd0,
      MODE_SENDING   = 2'd1,
      MODE_RECEIVING = 2'd2,
      MODE_BLOCKED   = 2'd3
   } mode_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

endpackage
`default_nettype wire

FILE: hdl/iub_ifs.sv
// Request and response channel interfaces of the bridge controller.
`default_nettype none
interface iub_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] bus_status;
   logic [7:0] data_byte;

   modport source (output valid, func, bus_status, data_byte, input ready);
   modport sink   (input valid, func, bus_status, data_byte, output ready);
endinterface

interface iub_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] bus_command;
   logic [7:0] bus_byte;
   logic       uart_send_valid;
   logic [7:0] uart_send_byte;
   logic       uart_ready_irq_on;
   logic       uart_side_full;
   logic       bus_side_full;

   modport source (output valid, bus_command, bus_byte, uart_send_valid, uart_send_byte,
                   uart_ready_irq_on, uart_side_full, bus_side_full, input ready);
   modport sink   (input valid, bus_command, bus_byte, uart_send_valid, uart_send_byte,
                   uart_ready_irq_on, uart_side_full, bus_side_full, output ready);
endinterface
`default_nettype wire

FILE: hdl/i2c_uart_bridge_controller.sv
// Top level of the UART / I2C bridge controller.
//
// Usage: every event of the UART or the I2C unit arrives as one item on the
// req_ch channel (func, bus_status, data_byte). Each item produces exactly one
// response item on rsp_ch: the I2C command to issue, a byte for the UART
// transmitter, the transmitter-empty interrupt enable and the two FIFO errors.
// Both FIFOs live in single-port synchronous memories; an item is read from
// them in the cycle it is accepted and written back when it commits to the
// output register.
// An accepted item is latched together with its memory read; the update stage then
// commits it to the output register, which makes the response valid. No new item
// is accepted until the previous one commits. A new item is taken while the
// previous response still waits; if the receiver stalls, the second item holds
// in the update stage until the output register frees. csr_we writes
// trigger_level (index 0) or target_address (index 1); other indexes are ignored.
// Reset (synchronous, active high) empties both FIFOs, stops the link,
// clears the pending request, marks the transmitter idle and loads
// trigger_level 16 and target_address 0. FIFO contents are not cleared.
`default_nettype none
module i2c_uart_bridge_controller #(
   parameter int SERIAL_DEPTH = iub_pkg::DEF_SERIAL_DEPTH,
   parameter int BUS_DEPTH    = iub_pkg::DEF_BUS_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   iub_req_if.sink                               req_ch,
   iub_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [iub_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [iub_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import iub_pkg::*;

   localparam int BA_W  = (BUS_DEPTH > 1) ? $clog2(BUS_DEPTH) : 1;
   localparam int BC_W  = $clog2(BUS_DEPTH + 1);
   localparam int SA_W  = (SERIAL_DEPTH > 1) ? $clog2(SERIAL_DEPTH) : 1;
   localparam int SC_W  = $clog2(SERIAL_DEPTH + 1);
   localparam int CMP_W = (BC_W > 7) ? BC_W : 7;

   localparam logic [BA_W-1:0] BUS_LAST    = BA_W'(BUS_DEPTH - 1);
   localparam logic [SA_W-1:0] SERIAL_LAST = SA_W'(SERIAL_DEPTH - 1);
   localparam logic [BC_W-1:0] BUS_FULL    = BC_W'(BUS_DEPTH);
   localparam logic [SC_W-1:0] SERIAL_FULL = SC_W'(SERIAL_DEPTH);

   // memories
   logic [7:0] bus_mem    [BUS_DEPTH];
   logic [7:0] serial_mem [SERIAL_DEPTH];

   // configuration
   logic [6:0] trigger_ff, trigger_in;
   logic [6:0] target_ff,  target_in;

   // control state
   fsm_type    fsm_ff, fsm_in;
   mode_type   mode_ff, mode_in;
   logic       pending_ff, pending_in;
   logic       tx_idle_ff, tx_idle_in;
   logic       irq_ff, irq_in;
   logic [BA_W-1:0] bus_head_ff, bus_head_in, bus_tail_ff, bus_tail_in;
   logic [BC_W-1:0] bus_cnt_ff, bus_cnt_in;
   logic [SA_W-1:0] ser_head_ff, ser_head_in, ser_tail_ff, ser_tail_in;
   logic [SC_W-1:0] ser_cnt_ff, ser_cnt_in;

   // latched item and read data
   func_type   func_ff;
   logic [7:0] status_ff;
   logic [7:0] data_ff;
   logic [7:0] bus_rd_ff;
   logic [7:0] ser_rd_ff;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   cmd_type    rsp_cmd_ff, rsp_cmd_in;
   logic [7:0] rsp_bbyte_ff, rsp_bbyte_in;
   logic       rsp_uvalid_ff, rsp_uvalid_in;
   logic [7:0] rsp_ubyte_ff, rsp_ubyte_in;
   logic       rsp_irq_ff;
   logic       rsp_sfull_ff, rsp_sfull_in;
   logic       rsp_bfull_ff, rsp_bfull_in;

   logic            req_fire;
   logic            commit;
   logic [BA_W-1:0] bus_tail_nxt, bus_head_nxt, bus_rd_addr;
   logic [SA_W-1:0] ser_tail_nxt, ser_head_nxt;
   logic [BC_W-1:0] bus_cnt_inc, bus_cnt_dec;
   logic [SC_W-1:0] ser_cnt_inc, ser_cnt_dec;
   logic            bus_wr_en, ser_wr_en;

   assign req_ch.ready = (fsm_ff == FSM_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign commit       = (fsm_ff == FSM_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign bus_tail_nxt = (bus_tail_ff == BUS_LAST) ? '0 : bus_tail_ff + 1'b1;
   assign bus_head_nxt = (bus_head_ff == BUS_LAST) ? '0 : bus_head_ff + 1'b1;
   assign ser_tail_nxt = (ser_tail_ff == SERIAL_LAST) ? '0 : ser_tail_ff + 1'b1;
   assign ser_head_nxt = (ser_head_ff == SERIAL_LAST) ? '0 : ser_head_ff + 1'b1;
   assign bus_cnt_inc  = bus_cnt_ff + 1'b1;
   assign bus_cnt_dec  = bus_cnt_ff - 1'b1;
   assign ser_cnt_inc  = ser_cnt_ff + 1'b1;
   assign ser_cnt_dec  = ser_cnt_ff - 1'b1;

   // data ACK drains first, so the next byte comes from one past the tail
   assign bus_rd_addr = (func_type'(req_ch.func) == FUNC_BUS_STATUS &&
                         req_ch.bus_status == I2C_MT_DATA_ACK &&
                         bus_cnt_ff != '0) ? bus_tail_nxt : bus_tail_ff;

   always_ff @(posedge clock) begin
      if (bus_wr_en) begin
         bus_mem[bus_head_ff] <= data_ff;
      end
      if (req_fire) begin
         bus_rd_ff <= bus_mem[bus_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ser_wr_en) begin
         serial_mem[ser_head_ff] <= data_ff;
      end
      if (req_fire) begin
         ser_rd_ff <= serial_mem[ser_tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff   <= func_type'(req_ch.func);
         status_ff <= req_ch.bus_status;
         data_ff   <= req_ch.data_byte;
      end
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_bbyte_ff  <= rsp_bbyte_in;
      rsp_uvalid_ff <= rsp_uvalid_in;
      rsp_ubyte_ff  <= rsp_ubyte_in;
      rsp_sfull_ff  <= rsp_sfull_in;
      rsp_bfull_ff  <= rsp_bfull_in;
      if (commit) begin
         rsp_irq_ff <= irq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         mode_ff      <= MODE_STOPPED;
         pending_ff   <= 1'b0;
         tx_idle_ff   <= 1'b1;
         irq_ff       <= 1'b0;
         bus_head_ff  <= '0;
         bus_tail_ff  <= '0;
         bus_cnt_ff   <= '0;
         ser_head_ff  <= '0;
         ser_tail_ff  <= '0;
         ser_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         trigger_ff   <= TRIGGER_RESET;
         target_ff    <= '0;
      end else begin
         fsm_ff       <= fsm_in;
         mode_ff      <= mode_in;
         pending_ff   <= pending_in;
         tx_idle_ff   <= tx_idle_in;
         irq_ff       <= irq_in;
         bus_head_ff  <= bus_head_in;
         bus_tail_ff  <= bus_tail_in;
         bus_cnt_ff   <= bus_cnt_in;
         ser_head_ff  <= ser_head_in;
         ser_tail_ff  <= ser_tail_in;
         ser_cnt_ff   <= ser_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         trigger_ff   <= trigger_in;
         target_ff    <= target_in;
      end
   end

   always_comb begin
      trigger_in = trigger_ff;
      target_in  = target_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TRIGGER_LEVEL:  trigger_in = csr_wdata;
            CSR_TARGET_ADDRESS: target_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      fsm_in        = fsm_ff;
      mode_in       = mode_ff;
      pending_in    = pending_ff;
      tx_idle_in    = tx_idle_ff;
      irq_in        = irq_ff;
      bus_head_in   = bus_head_ff;
      bus_tail_in   = bus_tail_ff;
      bus_cnt_in    = bus_cnt_ff;
      ser_head_in   = ser_head_ff;
      ser_tail_in   = ser_tail_ff;
      ser_cnt_in    = ser_cnt_ff;
      bus_wr_en     = 1'b0;
      ser_wr_en     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_bbyte_in  = rsp_bbyte_ff;
      rsp_uvalid_in = rsp_uvalid_ff;
      rsp_ubyte_in  = rsp_ubyte_ff;
      rsp_sfull_in  = rsp_sfull_ff;
      rsp_bfull_in  = rsp_bfull_ff;

      case (fsm_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               fsm_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (commit) begin
               fsm_in        = FSM_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_cmd_in    = CMD_NONE;
               rsp_bbyte_in  = '0;
               rsp_uvalid_in = 1'b0;
               rsp_ubyte_in  = '0;
               rsp_sfull_in  = 1'b0;
               rsp_bfull_in  = 1'b0;
               case (func_ff)
                  FUNC_UART_RX: begin
                     if (bus_cnt_ff != BUS_FULL) begin
                        bus_wr_en   = 1'b1;
                        bus_cnt_in  = bus_cnt_inc;
                        bus_head_in = bus_head_nxt;
                        if (CMP_W'(bus_cnt_inc) >= CMP_W'(trigger_ff)) begin
                           pending_in = 1'b1;
                        end
                     end else begin
                        rsp_bfull_in = 1'b1;
                     end
                  end
                  FUNC_BUS_STATUS: begin
                     case (status_ff)
                        I2C_MT_START: begin
                           rsp_cmd_in   = CMD_SEND;
                           rsp_bbyte_in = {target_ff, 1'b0};
                        end
                        I2C_MT_SLA_ACK: begin
                           rsp_cmd_in   = CMD_SEND;
                           rsp_bbyte_in = bus_rd_ff;
                        end
                        I2C_MT_DATA_ACK: begin
                           if (bus_cnt_ff > BC_W'(1)) begin
                              bus_cnt_in   = bus_cnt_dec;
                              bus_tail_in  = bus_tail_nxt;
                              rsp_cmd_in   = CMD_SEND;
                              rsp_bbyte_in = bus_rd_ff;
                           end else begin
                              bus_cnt_in  = '0;
                              bus_head_in = '0;
                              bus_tail_in = '0;
                              mode_in     = MODE_STOPPED;
                              rsp_cmd_in  = CMD_STOP;
                           end
                        end
                        I2C_MT_DATA_NACK: begin
                           mode_in    = MODE_STOPPED;
                           rsp_cmd_in = CMD_STOP;
                        end
                        I2C_ARB_LOST: begin
                           rsp_cmd_in = CMD_NONE;
                        end
                        I2C_SR_SLA_ACK: begin
                           mode_in    = MODE_RECEIVING;
                           rsp_cmd_in = (ser_cnt_ff != SERIAL_FULL) ? CMD_ACK : CMD_NACK;
                        end
                        I2C_SR_DATA_ACK: begin
                           if (ser_cnt_ff == '0 && tx_idle_ff) begin
                              rsp_uvalid_in = 1'b1;
                              rsp_ubyte_in  = data_ff;
                              tx_idle_in    = 1'b0;
                              irq_in        = 1'b1;
                              rsp_cmd_in    = CMD_ACK;
                           end else if (ser_cnt_ff != SERIAL_FULL) begin
                              ser_wr_en   = 1'b1;
                              ser_head_in = ser_head_nxt;
                              ser_cnt_in  = ser_cnt_inc;
                              if (ser_cnt_inc != SERIAL_FULL) begin
                                 rsp_cmd_in = CMD_ACK;
                              end else begin
                                 rsp_sfull_in = 1'b1;
                                 mode_in      = MODE_BLOCKED;
                                 rsp_cmd_in   = CMD_NACK;
                              end
                           end else begin
                              rsp_sfull_in = 1'b1;
                              mode_in      = MODE_BLOCKED;
                              rsp_cmd_in   = CMD_NACK;
                           end
                        end
                        I2C_SR_STOP: begin
                           mode_in    = MODE_STOPPED;
                           rsp_cmd_in = CMD_ACK;
                        end
                        default: begin
                           rsp_cmd_in = CMD_ACK;
                        end
                     endcase
                  end
                  FUNC_TX_EMPTY: begin
                     if (irq_ff) begin
                        if (ser_cnt_ff != '0) begin
                           rsp_uvalid_in = 1'b1;
                           rsp_ubyte_in  = ser_rd_ff;
                           ser_cnt_in    = ser_cnt_dec;
                           if (ser_cnt_dec != '0) begin
                              ser_tail_in = ser_tail_nxt;
                           end else begin
                              ser_head_in = '0;
                              ser_tail_in = '0;
                           end
                        end else begin
                           irq_in     = 1'b0;
                           tx_idle_in = 1'b1;
                        end
                     end
                  end
                  FUNC_POLL: begin
                     if (pending_ff && mode_ff == MODE_STOPPED) begin
                        pending_in = 1'b0;
                        mode_in    = MODE_SENDING;
                        rsp_cmd_in = CMD_START;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.bus_command       = rsp_cmd_ff;
   assign rsp_ch.bus_byte          = rsp_bbyte_ff;
   assign rsp_ch.uart_send_valid   = rsp_uvalid_ff;
   assign rsp_ch.uart_send_byte    = rsp_ubyte_ff;
   assign rsp_ch.uart_ready_irq_on = rsp_irq_ff;
   assign rsp_ch.uart_side_full    = rsp_sfull_ff;
   assign rsp_ch.bus_side_full     = rsp_bfull_ff;

`ifndef SYNTHESIS
   a_bus_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      bus_cnt_ff <= BUS_FULL)
      else $error("bus FIFO count above depth");

   a_ser_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      ser_cnt_ff <= SERIAL_FULL)
      else $error("serial FIFO count above depth");

   a_irq_tx_busy: assert property (@(posedge clock) disable iff (reset)
      irq_ff == !tx_idle_ff)
      else $error("transmitter-empty enable out of step with transmitter state");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (fsm_ff == FSM_EXEC))
      else $error("accepted item did not enter update stage");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed item produced no response");
`endif

endmodule
`default_nettype wire
